// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-16/Modbus byte update for the command frame
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  localparam int unsigned REG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_PREFIX_FIRST  = 2'd0,
    REG_PREFIX_SECOND = 2'd1,
    REG_PROTO_VERSION = 2'd2,
    REG_COMMAND_TYPE  = 2'd3
  } reg_index_t;

  localparam logic [7:0] PREFIX_FIRST_RST  = 8'd170;
  localparam logic [7:0] PREFIX_SECOND_RST = 8'd85;
  localparam logic [7:0] PROTO_VERSION_RST = 8'd1;
  localparam logic [7:0] COMMAND_TYPE_RST  = 8'd1;

  typedef struct packed {
    logic [7:0] prefix_first;
    logic [7:0] prefix_second;
    logic [7:0] protocol_version;
    logic [7:0] command_type;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_VER     = 3'd2,
    PH_TYPE    = 3'd3,
    PH_LENL    = 3'd4,
    PH_LENH    = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_CRC     = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_VER  = 3'd1,
    STS_BAD_TYPE = 3'd2,
    STS_BAD_LEN  = 3'd3,
    STS_BAD_CRC  = 3'd4
  } status_t;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  CMD_BODY_LEN = 8'd7;

  // payload byte positions
  localparam logic [2:0] POS_THR_LO = 3'd2;
  localparam logic [2:0] POS_THR_HI = 3'd3;
  localparam logic [2:0] POS_STR_LO = 3'd4;
  localparam logic [2:0] POS_STR_HI = 3'd5;
  localparam logic [2:0] POS_LAST   = 3'd6;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfd_if.sv =====
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels of the deframer: received bytes in, frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_result_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [15:0] throttle_raw;
  logic signed [15:0] steering_raw;

  modport source (output valid, output status, output throttle_raw,
                  output steering_raw, input ready);
  modport sink   (input valid, input status, input throttle_raw,
                  input steering_raw, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// APB register file holding the prefix, version and command type bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cfd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output cfd_pkg::cfg_t                       cfg
);
  import cfd_pkg::*;

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[REG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_first     <= PREFIX_FIRST_RST;
      cfg.prefix_second    <= PREFIX_SECOND_RST;
      cfg.protocol_version <= PROTO_VERSION_RST;
      cfg.command_type     <= COMMAND_TYPE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PREFIX_FIRST:  cfg.prefix_first     <= pwdata[7:0];
        REG_PREFIX_SECOND: cfg.prefix_second    <= pwdata[7:0];
        REG_PROTO_VERSION: cfg.protocol_version <= pwdata[7:0];
        REG_COMMAND_TYPE:  cfg.command_type     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PREFIX_FIRST:  prdata = {24'd0, cfg.prefix_first};
      REG_PREFIX_SECOND: prdata = {24'd0, cfg.prefix_second};
      REG_PROTO_VERSION: prdata = {24'd0, cfg.protocol_version};
      REG_COMMAND_TYPE:  prdata = {24'd0, cfg.command_type};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/command_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// command_frame_deframer
// Byte-stream parser for prefixed command frames with CRC-16/Modbus check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on rx and reports, on result, one
// transaction per completed or rejected frame: status 0 with the raw signed
// throttle and steering, or an error code (bad version, type, length or CRC).
// Bytes outside a frame give no result. A byte is registered in the input
// register at acceptance and parsed from there, with the CRC byte update done
// combinationally, and each report is held in the result register.
// Sustained rate is one byte per cycle; it drops only while a result waits
// on result.ready, and then the input register stalls after one more byte.
// Prefix, version and type are set through the APB port; write them only
// while the stream is idle.
`default_nettype none

module command_frame_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  cfd_rx_if.sink                              rx,
  cfd_result_if.source                        result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cfd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import cfd_pkg::*;

  cfg_t cfg;

  cfd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;

  assign advance  = byte_valid && (!result.valid || result.ready);
  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  pos, pos_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [15:0] thr_hold, thr_hold_next;
  logic [15:0] str_hold, str_hold_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [15:0] crc_fold_b;
  logic        emit;
  status_t     emit_status;
  logic [15:0] emit_thr;
  logic [15:0] emit_str;

  assign crc_fold_b = crc_fold(crc, byte_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT0;
      pos      <= 3'd0;
      crc      <= CRC_INIT;
      len_lo   <= 8'd0;
      thr_hold <= 16'd0;
      str_hold <= 16'd0;
      crc_lo   <= 8'd0;
    end else if (advance) begin
      phase    <= phase_next;
      pos      <= pos_next;
      crc      <= crc_next;
      len_lo   <= len_lo_next;
      thr_hold <= thr_hold_next;
      str_hold <= str_hold_next;
      crc_lo   <= crc_lo_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    crc_next      = crc;
    len_lo_next   = len_lo;
    thr_hold_next = thr_hold;
    str_hold_next = str_hold;
    crc_lo_next   = crc_lo;
    emit          = 1'b0;
    emit_status   = STS_OK;
    emit_thr      = 16'd0;
    emit_str      = 16'd0;
    case (phase)
      PH_HUNT0: begin
        if (byte_q == cfg.prefix_first) phase_next = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (byte_q == cfg.prefix_second) begin
          phase_next = PH_VER;
          crc_next   = CRC_INIT;
          pos_next   = 3'd0;
        end else if (byte_q != cfg.prefix_first) begin
          phase_next = PH_HUNT0;
        end
      end
      PH_VER: begin
        if (byte_q != cfg.protocol_version) begin
          emit        = 1'b1;
          emit_status = STS_BAD_VER;
        end else begin
          crc_next   = crc_fold_b;
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (byte_q != cfg.command_type) begin
          emit        = 1'b1;
          emit_status = STS_BAD_TYPE;
        end else begin
          crc_next   = crc_fold_b;
          phase_next = PH_LENL;
        end
      end
      PH_LENL: begin
        len_lo_next = byte_q;
        crc_next    = crc_fold_b;
        phase_next  = PH_LENH;
      end
      PH_LENH: begin
        if (len_lo != CMD_BODY_LEN || byte_q != 8'd0) begin
          emit        = 1'b1;
          emit_status = STS_BAD_LEN;
        end else begin
          crc_next   = crc_fold_b;
          phase_next = PH_PAYLOAD;
          pos_next   = 3'd0;
        end
      end
      PH_PAYLOAD: begin
        crc_next = crc_fold_b;
        case (pos)
          POS_THR_LO: thr_hold_next[7:0]  = byte_q;
          POS_THR_HI: thr_hold_next[15:8] = byte_q;
          POS_STR_LO: str_hold_next[7:0]  = byte_q;
          POS_STR_HI: str_hold_next[15:8] = byte_q;
          default: ;
        endcase
        if (pos == POS_LAST) begin
          phase_next = PH_CRC;
          pos_next   = 3'd0;
        end else begin
          pos_next = pos + 3'd1;
        end
      end
      PH_CRC: begin
        if (pos == 3'd0) begin
          crc_lo_next = byte_q;
          pos_next    = 3'd1;
        end else if ({byte_q, crc_lo} != crc) begin
          emit        = 1'b1;
          emit_status = STS_BAD_CRC;
        end else begin
          emit        = 1'b1;
          emit_status = STS_OK;
          emit_thr    = thr_hold;
          emit_str    = str_hold;
        end
      end
      default: phase_next = PH_HUNT0;
    endcase
    if (emit) begin
      phase_next = PH_HUNT0;
      pos_next   = 3'd0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result.status       <= emit_status;
      result.throttle_raw <= $signed(emit_thr);
      result.steering_raw <= $signed(emit_str);
    end
  end

  // checks
  a_emit_rehunt: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> phase == PH_HUNT0 && pos == 3'd0)
    else $error("parser not back to hunting after a result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != STS_OK |->
      result.throttle_raw == 16'sd0 && result.steering_raw == 16'sd0)
    else $error("error result carries nonzero payload");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PAYLOAD || pos <= POS_LAST) && (phase != PH_CRC || pos <= 3'd1))
    else $error("byte position out of range");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !advance)
    else $error("parser advanced over a pending result");

endmodule

`default_nettype wire

// ===== verif/tb_command_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_command_frame_deframer
// Self-checking bench for the command frame deframer.
// ----------------------------------------------------------------------------
// Feeds byte streams built from prefixed command frames (good, corrupted,
// truncated) and line noise. Each byte is run through a local parser model at
// acceptance, and the predicted frame reports are compared against the
// result channel. Prefix, version and type are reprogrammed over APB between
// phases, including all-zero and all-ones settings. Random gaps on the input
// side and random stalls on the result side, with a back-to-back phase.
// ----------------------------------------------------------------------------
module tb_command_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import cfd_pkg::*;

  localparam int LATENCY_WAIT   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] throttle;
    logic signed [15:0] steering;
  } report_t;

  typedef enum int {FR_GOOD, FR_BAD_VER, FR_BAD_TYPE, FR_BAD_CRC} frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  cfd_rx_if     rx_ch();
  cfd_result_if res_ch();

  command_frame_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser model: configuration and state
  logic [7:0]  m_pf, m_ps, m_ver, m_type;
  phase_t      m_phase;
  logic [3:0]  m_pos;
  logic [15:0] m_crc;
  logic [7:0]  m_len_lo;
  logic [7:0]  m_crc_lo;
  logic [15:0] m_thr;
  logic [15:0] m_str;

  report_t expected_reports[$];
  int      mismatches;
  int      n_sent;
  int      n_reports;
  int      sts_count[8];
  int      quiet;
  bit      gaps_on;
  bit      stalls_on;

  function automatic logic [15:0] crc16_update(input logic [15:0] c,
                                               input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // advances the model by one byte; returns 1 when the byte completes a report
  function automatic bit deframe_byte(input logic [7:0] b, output report_t r);
    logic [15:0] len;
    bit          done;
    r    = '0;
    done = 1'b0;
    case (m_phase)
      PH_HUNT0: begin
        if (b == m_pf) m_phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b == m_ps) begin
          m_phase = PH_VER;
          m_crc   = CRC_INIT;
          m_pos   = '0;
        end else if (b != m_pf) begin
          m_phase = PH_HUNT0;
        end
      end
      PH_VER: begin
        if (b != m_ver) begin
          r.status = STS_BAD_VER;
          done     = 1'b1;
        end else begin
          m_crc   = crc16_update(m_crc, b);
          m_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b != m_type) begin
          r.status = STS_BAD_TYPE;
          done     = 1'b1;
        end else begin
          m_crc   = crc16_update(m_crc, b);
          m_phase = PH_LENL;
        end
      end
      PH_LENL: begin
        m_len_lo = b;
        m_crc    = crc16_update(m_crc, b);
        m_phase  = PH_LENH;
      end
      PH_LENH: begin
        len = {b, m_len_lo};
        if (len != {8'd0, CMD_BODY_LEN}) begin
          r.status = STS_BAD_LEN;
          done     = 1'b1;
        end else begin
          m_crc   = crc16_update(m_crc, b);
          m_phase = PH_PAYLOAD;
          m_pos   = '0;
        end
      end
      PH_PAYLOAD: begin
        m_crc = crc16_update(m_crc, b);
        case (m_pos[2:0])
          POS_THR_LO: m_thr[7:0]  = b;
          POS_THR_HI: m_thr[15:8] = b;
          POS_STR_LO: m_str[7:0]  = b;
          POS_STR_HI: m_str[15:8] = b;
          default: ;
        endcase
        m_pos = m_pos + 4'd1;
        if (m_pos >= CMD_BODY_LEN) begin
          m_phase = PH_CRC;
          m_pos   = '0;
        end
      end
      default: begin
        if (m_pos == 4'd0) begin
          m_crc_lo = b;
          m_pos    = 4'd1;
        end else begin
          if ({b, m_crc_lo} != m_crc) begin
            r.status = STS_BAD_CRC;
          end else begin
            r.status   = STS_OK;
            r.throttle = m_thr;
            r.steering = m_str;
          end
          done = 1'b1;
        end
      end
    endcase
    if (done) begin
      m_phase = PH_HUNT0;
      m_pos   = '0;
    end
    return done;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    report_t r;
    while (gaps_on && $urandom_range(99) < 26) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    n_sent++;
    if (deframe_byte(b, r)) begin
      expected_reports.push_back(r);
    end
  endtask

  // keep: number of leading bytes actually sent (15 = whole frame)
  task automatic send_frame(input frame_kind_t kind, input logic [15:0] thr,
                            input logic [15:0] str, input logic [15:0] len_field,
                            input int keep = 15);
    logic [7:0]  body[$];
    logic [7:0]  f[$];
    logic [7:0]  v;
    logic [7:0]  t;
    logic [15:0] crc;
    v = m_ver;
    t = m_type;
    if (kind == FR_BAD_VER) v = m_ver ^ 8'($urandom_range(255, 1));
    if (kind == FR_BAD_TYPE) t = m_type ^ 8'($urandom_range(255, 1));
    body = {v, t, len_field[7:0], len_field[15:8], 8'($urandom), 8'($urandom),
            thr[7:0], thr[15:8], str[7:0], str[15:8], 8'($urandom)};
    crc = CRC_INIT;
    foreach (body[i]) crc = crc16_update(crc, body[i]);
    if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(65535, 1));
    f.push_back(m_pf);
    f.push_back(m_ps);
    foreach (body[i]) f.push_back(body[i]);
    f.push_back(crc[7:0]);
    f.push_back(crc[15:8]);
    for (int i = 0; i < keep && i < f.size(); i++) begin
      send_byte(f[i]);
    end
  endtask

  task automatic hold_until_drained;
    rx_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic program_register(input reg_index_t idx, input logic [7:0] v);
    logic [7:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back    = prdata[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (back !== v) begin
      $error("readback %s: expected %0d, got %0d", idx.name(), v, back);
      mismatches++;
    end
    case (idx)
      REG_PREFIX_FIRST:  m_pf   = v;
      REG_PREFIX_SECOND: m_ps   = v;
      REG_PROTO_VERSION: m_ver  = v;
      REG_COMMAND_TYPE:  m_type = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] pf, input logic [7:0] ps,
                            input logic [7:0] ver, input logic [7:0] typ);
    hold_until_drained;
    program_register(REG_PREFIX_FIRST, pf);
    program_register(REG_PREFIX_SECOND, ps);
    program_register(REG_PROTO_VERSION, ver);
    program_register(REG_COMMAND_TYPE, typ);
  endtask

  // mostly well-formed frames, with corrupted, truncated and noise traffic mixed in
  task automatic run_stream(input int budget);
    int          first;
    int          pick;
    bit          paused;
    logic [15:0] len;
    first  = n_sent;
    paused = 1'b0;
    while (n_sent - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(FR_GOOD, pick_word(), pick_word(), 16'd7);
      end else if (pick < 68) begin
        send_frame(FR_BAD_VER, pick_word(), pick_word(), 16'd7);
      end else if (pick < 74) begin
        send_frame(FR_BAD_TYPE, pick_word(), pick_word(), 16'd7);
      end else if (pick < 80) begin
        len = 16'($urandom);
        if (len == 16'd7) len = 16'h0107;
        send_frame(FR_GOOD, pick_word(), pick_word(), len);
      end else if (pick < 88) begin
        send_frame(FR_BAD_CRC, pick_word(), pick_word(), 16'd7);
      end else if (pick < 94) begin
        send_frame(FR_GOOD, pick_word(), pick_word(), 16'd7, $urandom_range(14, 3));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end
      if (!paused && n_sent - first >= budget / 2) begin
        hold_until_drained;
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_directed_frames;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(FR_GOOD, 16'h7FFF, 16'h8000, 16'd7);
    send_frame(FR_GOOD, 16'h8000, 16'h7FFF, 16'd7);
    send_frame(FR_GOOD, 16'hFFFF, 16'h0000, 16'd7);
    send_frame(FR_BAD_VER, 16'd0, 16'd0, 16'd7, 3);
    send_frame(FR_BAD_TYPE, 16'd0, 16'd0, 16'd7, 4);
    send_frame(FR_GOOD, 16'd0, 16'd0, 16'h0107, 6);
    send_frame(FR_GOOD, 16'd0, 16'd0, 16'h0006, 6);
    send_frame(FR_BAD_CRC, 16'h1234, 16'h5678, 16'd7);
    hold_until_drained;
  endtask

  task automatic test_prefix_handling;
    // doubled first prefix byte
    send_byte(m_pf);
    send_byte(m_pf);
    send_frame(FR_GOOD, 16'h0102, 16'hFEFD, 16'd7);
    // broken prefix pair
    send_byte(m_pf);
    send_byte(8'h3C);
    send_frame(FR_GOOD, 16'h2000, 16'hE000, 16'd7);
    // rejecting byte is itself a prefix byte and must not restart the hunt
    send_byte(m_pf);
    send_byte(m_ps);
    send_byte(m_pf);
    send_byte(m_ps);
    send_frame(FR_GOOD, 16'h0001, 16'hFFFE, 16'd7);
    hold_until_drained;
  endtask

  task automatic test_back_to_back;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_stream(150);
    hold_until_drained;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_extreme_configs;
    // equal prefix bytes
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(FR_GOOD, 16'h7FFF, 16'h7FFF, 16'd7);
    run_stream(100);
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(FR_GOOD, 16'h8000, 16'h8000, 16'd7);
    run_stream(100);
  endtask

  task automatic test_random_configs;
    repeat (2) begin
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_stream(80);
    end
    set_config(PREFIX_FIRST_RST, PREFIX_SECOND_RST, PROTO_VERSION_RST, COMMAND_TYPE_RST);
    run_stream(60);
  endtask

  // result side: random stalls and report checking
  always @(posedge clk) begin
    report_t want;
    res_ch.ready <= !stalls_on || ($urandom_range(99) >= 26);
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: status %0d", res_ch.status);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        n_reports++;
        sts_count[want.status]++;
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatches++;
        end
        if (res_ch.throttle_raw !== want.throttle) begin
          $error("throttle_raw: expected %0d, got %0d", want.throttle,
                 res_ch.throttle_raw);
          mismatches++;
        end
        if (res_ch.steering_raw !== want.steering) begin
          $error("steering_raw: expected %0d, got %0d", want.steering,
                 res_ch.steering_raw);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_command_frame_deframer: errors");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    mismatches    = 0;
    n_sent        = 0;
    n_reports     = 0;
    quiet         = 0;
    foreach (sts_count[i]) sts_count[i] = 0;
    m_pf     = PREFIX_FIRST_RST;
    m_ps     = PREFIX_SECOND_RST;
    m_ver    = PROTO_VERSION_RST;
    m_type   = COMMAND_TYPE_RST;
    m_phase  = PH_HUNT0;
    m_pos    = '0;
    m_crc    = CRC_INIT;
    m_len_lo = '0;
    m_crc_lo = '0;
    m_thr    = '0;
    m_str    = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames;
    test_prefix_handling;
    test_back_to_back;
    test_extreme_configs;
    test_random_configs;
    hold_until_drained;

    $display("%0d bytes sent, %0d reports checked", n_sent, n_reports);
    $display("ok %0d, version %0d, type %0d, length %0d, crc %0d",
             sts_count[STS_OK], sts_count[STS_BAD_VER], sts_count[STS_BAD_TYPE],
             sts_count[STS_BAD_LEN], sts_count[STS_BAD_CRC]);
    $display("register values: reset, all-zero, all-ones, random; gapped/stalled and back-to-back");
    if (mismatches == 0) begin
      $display("tb_command_frame_deframer: clean");
    end else begin
      $display("tb_command_frame_deframer: errors");
    end
    $finish;
  end

endmodule
